// ----- src/aces_pkg.sv -----
// shared constants and the gamma threshold function for the aces tone map pixel block
package aces_pkg;

	localparam int IN_W   = 24;
	localparam int CODE_W = 8;
	localparam int CODES  = 1 << CODE_W;
	localparam int WIDE_W = 192;

	// smallest quantized value q in 0..2^g whose gamma code is at least k
	function automatic int gamma_thr(input int k, input int g);
		logic [WIDE_W-1:0] lhs;
		logic [WIDE_W-1:0] rhs;
		logic [WIDE_W-1:0] c255;
		int lo;
		int hi;
		int mid;
		lhs = WIDE_W'(1);
		for (int i = 0; i < 11; i++) begin
			lhs = lhs * WIDE_W'(k);
		end
		lhs = lhs << (5 * g);
		c255 = WIDE_W'(1);
		for (int i = 0; i < 11; i++) begin
			c255 = c255 * WIDE_W'(CODES - 1);
		end
		lo = 0;
		hi = 1 << g;
		while (lo < hi) begin
			mid = (lo + hi) >> 1;
			rhs = c255;
			for (int i = 0; i < 5; i++) begin
				rhs = rhs * WIDE_W'(mid);
			end
			if (rhs >= lhs) begin
				hi = mid;
			end else begin
				lo = mid + 1;
			end
		end
		return lo;
	endfunction

endpackage

// ----- src/aces_chan.sv -----
// one color channel: filmic fit, pipelined restoring divide, gamma code search
module aces_chan import aces_pkg::*; #(
	parameter int FRAC_BITS        = 16,
	parameter int GAMMA_INDEX_BITS = 12,
	parameter int NS               = 3 + GAMMA_INDEX_BITS + CODE_W
) (
	input  logic              clk,
	input  logic [NS-1:0]     ld,
	input  logic [IN_W-1:0]   x,
	output logic [CODE_W-1:0] code
);

	localparam int G    = GAMMA_INDEX_BITS;
	localparam int SQ_W = 2 * IN_W;
	localparam int T1   = SQ_W + 8;
	localparam int T2   = IN_W + FRAC_BITS + 6;
	localparam int T3   = 2 * FRAC_BITS + 4;
	localparam int TM   = (T1 > T2) ? ((T1 > T3) ? T1 : T3) : ((T2 > T3) ? T2 : T3);
	localparam int DW   = TM + 2;

	logic [IN_W-1:0] x_s1;
	logic [SQ_W-1:0] sq_s1;
	logic [DW-1:0]   num_s2;
	logic [DW-1:0]   den_s2;

	logic [DW-1:0]   div_rem_s [G+1];
	logic [DW-1:0]   div_den_s [G+1];
	logic [G-1:0]    div_q_s   [G+1];
	logic            div_sat_s [G+1];

	logic [G:0]        srch_q_s [CODE_W+1];
	logic [CODE_W-1:0] srch_k_s [CODE_W+1];

	logic [G:0] thr [CODES];

	for (genvar k = 0; k < CODES; k++) begin : g_thr
		assign thr[k] = (G+1)'(gamma_thr(k, G));
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			x_s1  <= x;
			sq_s1 <= SQ_W'(x) * SQ_W'(x);
		end
		if (ld[1]) begin
			num_s2 <= DW'(sq_s1) * DW'(251) + ((DW'(x_s1) * DW'(3)) << FRAC_BITS);
			den_s2 <= DW'(sq_s1) * DW'(243) + ((DW'(x_s1) * DW'(59)) << FRAC_BITS)
				+ (DW'(14) << (2 * FRAC_BITS));
		end
		if (ld[2]) begin
			div_sat_s[0] <= num_s2 >= den_s2;
			div_rem_s[0] <= num_s2;
			div_den_s[0] <= den_s2;
			div_q_s[0]   <= '0;
		end
	end

	for (genvar j = 0; j < G; j++) begin : g_div
		logic [DW:0] r2;
		logic        ge;
		assign r2 = {div_rem_s[j], 1'b0};
		assign ge = r2 >= {1'b0, div_den_s[j]};
		always_ff @(posedge clk) begin
			if (ld[3+j]) begin
				div_rem_s[j+1] <= ge ? DW'(r2 - {1'b0, div_den_s[j]}) : DW'(r2);
				div_den_s[j+1] <= div_den_s[j];
				div_q_s[j+1]   <= {div_q_s[j][G-2:0], ge};
				div_sat_s[j+1] <= div_sat_s[j];
			end
		end
	end

	assign srch_q_s[0] = div_sat_s[G] ? (G+1)'(1 << G) : {1'b0, div_q_s[G]};
	assign srch_k_s[0] = '0;

	for (genvar j = 0; j < CODE_W; j++) begin : g_srch
		logic [CODE_W-1:0] cand;
		assign cand = srch_k_s[j] | CODE_W'(1 << (CODE_W - 1 - j));
		always_ff @(posedge clk) begin
			if (ld[3+G+j]) begin
				srch_q_s[j+1] <= srch_q_s[j];
				srch_k_s[j+1] <= (thr[cand] <= srch_q_s[j]) ? cand : srch_k_s[j];
			end
		end
	end

	assign code = srch_k_s[CODE_W];

endmodule

// ----- src/aces_tone_map_gamma_pixel.sv -----
// top level of the aces filmic tone map and gamma pixel stage
// Takes one pixel per clock while in_stall is low and returns its 8-bit display codes.
// In the pipeline two stages form the filmic numerator and denominator, one checks
// saturation, one restoring divide step runs per quantized bit, and eight steps of a
// binary search run over the gamma threshold table.
// Each stage holds its item under stall and empty stages fill, so bubbles are squeezed out.
module aces_tone_map_gamma_pixel import aces_pkg::*; #(
	parameter int FRAC_BITS        = 16,
	parameter int GAMMA_INDEX_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [IN_W-1:0]   hdr_red,
	input  logic [IN_W-1:0]   hdr_green,
	input  logic [IN_W-1:0]   hdr_blue,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CODE_W-1:0] out_red,
	output logic [CODE_W-1:0] out_green,
	output logic [CODE_W-1:0] out_blue
);

	localparam int NS = 3 + GAMMA_INDEX_BITS + CODE_W;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] ld;

	always_comb begin
		ld[NS-1] = !vld_q[NS-1] || !out_stall;
		for (int i = NS - 2; i >= 0; i--) begin
			ld[i] = !vld_q[i] || ld[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (ld[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign in_stall  = !ld[0];
	assign out_valid = vld_q[NS-1];

	aces_chan #(.FRAC_BITS(FRAC_BITS), .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS), .NS(NS)) u_red (
		.clk(clk), .ld(ld), .x(hdr_red), .code(out_red)
	);

	aces_chan #(.FRAC_BITS(FRAC_BITS), .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS), .NS(NS)) u_green (
		.clk(clk), .ld(ld), .x(hdr_green), .code(out_green)
	);

	aces_chan #(.FRAC_BITS(FRAC_BITS), .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS), .NS(NS)) u_blue (
		.clk(clk), .ld(ld), .x(hdr_blue), .code(out_blue)
	);

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for the aces tone map and gamma pixel stage
`timescale 1ns / 1ps

module testbench;
	import aces_pkg::*;

	localparam int FRAC      = 16;
	localparam int GIDX      = 12;
	localparam int N_RANDOM  = 1030;
	localparam int DRAIN_AT  = 700;
	localparam int HOLD_AT   = 300;
	localparam int HOLD_LEN  = 300;
	localparam int DOG_LIMIT = 3000;
	localparam int TAIL      = 40;

	typedef struct {
		logic [IN_W-1:0] r;
		logic [IN_W-1:0] g;
		logic [IN_W-1:0] b;
		bit              drain;
		bit              nogap;
	} pixel_t;

	typedef struct {
		logic [CODE_W-1:0] r;
		logic [CODE_W-1:0] g;
		logic [CODE_W-1:0] b;
	} codes_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [IN_W-1:0]   hdr_red;
	logic [IN_W-1:0]   hdr_green;
	logic [IN_W-1:0]   hdr_blue;
	logic              out_valid;
	logic              out_stall;
	logic [CODE_W-1:0] out_red;
	logic [CODE_W-1:0] out_green;
	logic [CODE_W-1:0] out_blue;

	pixel_t pending_pixels[$];
	codes_t expected_codes[$];
	int     sent_cnt;
	int     recv_cnt;
	int     mismatch_cnt = 0;
	int     saturated_cnt = 0;
	int     gap_cnt;
	int     stall_cnt;
	int     hold_cnt;
	bit     hold_done;
	int     idle_cycles = 0;

	aces_tone_map_gamma_pixel #(
		.FRAC_BITS(FRAC),
		.GAMMA_INDEX_BITS(GIDX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.hdr_red(hdr_red),
		.hdr_green(hdr_green),
		.hdr_blue(hdr_blue),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue)
	);

	function automatic int unsigned filmic_index(logic [IN_W-1:0] xin);
		logic [63:0] x;
		logic [63:0] one;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] rem;
		int unsigned q;
		x = 64'(xin);
		one = 64'd1 << FRAC;
		num = x * (64'd251 * x + 64'd3 * one);
		den = x * (64'd243 * x + 64'd59 * one) + 64'd14 * (one * one);
		if (num >= den) begin
			return 1 << GIDX;
		end
		rem = num;
		q = 0;
		for (int i = 0; i < GIDX; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q = q | 1;
			end
		end
		return q;
	endfunction

	function automatic logic [CODE_W-1:0] display_code(logic [IN_W-1:0] xin);
		logic [159:0] rhs;
		logic [159:0] lhs;
		int unsigned q;
		int lo;
		int hi;
		int mid;
		q = filmic_index(xin);
		rhs = 160'd1;
		for (int i = 0; i < 5; i++) begin
			rhs = rhs * 160'(q);
		end
		for (int i = 0; i < 11; i++) begin
			rhs = rhs * 160'd255;
		end
		lo = 0;
		hi = 255;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			lhs = 160'd1;
			for (int i = 0; i < 11; i++) begin
				lhs = lhs * 160'(mid);
			end
			lhs = lhs << (5 * GIDX);
			if (lhs <= rhs) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return CODE_W'(lo);
	endfunction

	function automatic logic [IN_W-1:0] random_channel();
		case ($urandom_range(0, 3))
			0: return IN_W'($urandom);
			1: return IN_W'($urandom_range(0, 1 << (FRAC + 1)));
			2: return IN_W'($urandom_range(0, 1 << (FRAC - 4)));
			default: return IN_W'($urandom_range(0, 1 << (FRAC + 4)));
		endcase
	endfunction

	task automatic add_pixel(logic [IN_W-1:0] r, logic [IN_W-1:0] g, logic [IN_W-1:0] b);
		pixel_t p;
		p.r = r;
		p.g = g;
		p.b = b;
		p.drain = (pending_pixels.size() == DRAIN_AT);
		p.nogap = (pending_pixels.size() >= 500 && pending_pixels.size() < 600);
		pending_pixels.push_back(p);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		codes_t c;
		pixel_t p;
		if (!arst_n) begin
			in_valid <= 1'b0;
			hdr_red <= '0;
			hdr_green <= '0;
			hdr_blue <= '0;
			gap_cnt <= 0;
			sent_cnt <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				c.r = display_code(hdr_red);
				c.g = display_code(hdr_green);
				c.b = display_code(hdr_blue);
				if (c.r == 8'd255 || c.g == 8'd255 || c.b == 8'd255) begin
					saturated_cnt++;
				end
				expected_codes.push_back(c);
				sent_cnt <= sent_cnt + 1;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_cnt > 0) begin
					gap_cnt <= gap_cnt - 1;
					in_valid <= 1'b0;
				end else if (pending_pixels.size() > 0 &&
						!(pending_pixels[0].drain && expected_codes.size() > 0)) begin
					p = pending_pixels.pop_front();
					hdr_red <= p.r;
					hdr_green <= p.g;
					hdr_blue <= p.b;
					in_valid <= 1'b1;
					gap_cnt <= p.nogap ? 0 : $urandom_range(0, 9);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		codes_t c;
		bit took;
		int n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_cnt <= 0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
			recv_cnt <= 0;
		end else begin
			took = out_valid && !out_stall;
			if (took) begin
				recv_cnt <= recv_cnt + 1;
				if (expected_codes.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$display("unexpected transaction: %0d %0d %0d",
							out_red, out_green, out_blue);
					end
				end else begin
					c = expected_codes.pop_front();
					if (c.r !== out_red || c.g !== out_green || c.b !== out_blue) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("mismatch at %0d: expected %0d %0d %0d, got %0d %0d %0d",
								recv_cnt, c.r, c.g, c.b, out_red, out_green, out_blue);
						end
					end
				end
			end
			if (!hold_done && recv_cnt == HOLD_AT) begin
				hold_done <= 1'b1;
				hold_cnt <= HOLD_LEN;
				out_stall <= 1'b1;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				out_stall <= (hold_cnt > 1);
			end else if (took) begin
				n = (recv_cnt >= 500 && recv_cnt < 600) ? 0 : $urandom_range(0, 9);
				stall_cnt <= n;
				out_stall <= (n > 0);
			end else if (stall_cnt > 0) begin
				stall_cnt <= stall_cnt - 1;
				out_stall <= (stall_cnt > 1);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= DOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		add_pixel(24'd0, 24'd0, 24'd0);
		add_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		add_pixel(24'd1, 24'd2, 24'd3);
		add_pixel(24'h010000, 24'h008000, 24'h020000);
		add_pixel(24'hFF0000, 24'h00FFFF, 24'h000FFF);
		add_pixel(24'h555555, 24'hAAAAAA, 24'h800000);
		add_pixel(24'h000100, 24'h000010, 24'h004000);
		for (int i = 0; i < IN_W; i += 2) begin
			add_pixel(IN_W'(1) << i, IN_W'(1) << (i + 1), ~(IN_W'(1) << i));
		end
		add_pixel(24'h0C0000, 24'h100000, 24'h0A0000);
		for (int i = 0; i < N_RANDOM; i++) begin
			add_pixel(random_channel(), random_channel(), random_channel());
		end
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_pixels.size() == 0 && !in_valid && expected_codes.size() == 0);
		repeat (TAIL) @(posedge clk);
		$display("pixels sent %0d, received %0d, with a saturated channel %0d",
			sent_cnt, recv_cnt, saturated_cnt);
		$display("covered long output hold, drain pause and back-to-back stretches");
		if (mismatch_cnt == 0 && expected_codes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- aces_tone_map_gamma_pixel.f -----
src/aces_pkg.sv
src/aces_chan.sv
src/aces_tone_map_gamma_pixel.sv
verif/testbench.sv
